// ----- rtl/core/acpu_pkg.sv -----
`timescale 1ns / 1ps

package acpu_pkg;

  // Memory geometry.
  localparam int MEM_DEPTH = 32;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int DATA_W    = 8;
  localparam int OPC_W     = 3;

  // Operation codes held in bits 7..5 of an instruction byte.
  typedef logic [OPC_W-1:0] acpu_opc_t;
  localparam acpu_opc_t OPC_HLT = 3'd0;
  localparam acpu_opc_t OPC_SKZ = 3'd1;
  localparam acpu_opc_t OPC_ADD = 3'd2;
  localparam acpu_opc_t OPC_AND = 3'd3;
  localparam acpu_opc_t OPC_XOR = 3'd4;
  localparam acpu_opc_t OPC_LDA = 3'd5;
  localparam acpu_opc_t OPC_STO = 3'd6;
  localparam acpu_opc_t OPC_JMP = 3'd7;

  // Item codes carried in the op field.
  localparam logic ITEM_LOAD = 1'b0;
  localparam logic ITEM_STEP = 1'b1;

  // Input item.
  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] load_address;
    logic [DATA_W-1:0] load_data;
  } acpu_in_t;

  // Result item.
  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [DATA_W-1:0] acc;
    logic              zero_flag;
    logic [DATA_W-1:0] data_value;
    logic [DATA_W-1:0] instruction;
    logic              halted;
  } acpu_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;   // write the input byte into memory
    logic decode;    // latch the fetched instruction and run control ops
    logic execute;   // apply the fetched operand to the accumulator
    logic capture;   // load the result register
  } acpu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic halted;
    logic needs_operand;
  } acpu_sts_t;

endpackage

// ----- rtl/core/acpu_dp.sv -----
`timescale 1ns / 1ps

module acpu_dp import acpu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  acpu_in_t  in_data_i,
  input  acpu_cmd_t cmd_i,
  output acpu_sts_t sts_o,
  output acpu_out_t out_data_o
);

  logic [DATA_W-1:0] mem_q [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic              mem_we;

  logic [ADDR_W-1:0] pc_q, pc_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              zero_q, zero_d;
  logic [DATA_W-1:0] dreg_q, dreg_d;
  logic [DATA_W-1:0] ir_q, ir_d;
  logic              halt_q, halt_d;
  acpu_out_t         out_q;

  acpu_opc_t         fetch_opc;
  logic [ADDR_W-1:0] fetch_opd;
  acpu_opc_t         ir_opc;
  logic [ADDR_W-1:0] pc_inc;

  // The fetched instruction sits in the read register during decode.
  assign fetch_opc = rdata_q[DATA_W-1 -: OPC_W];
  assign fetch_opd = rdata_q[ADDR_W-1:0];
  assign ir_opc    = ir_q[DATA_W-1 -: OPC_W];
  assign pc_inc    = pc_q + ADDR_W'(1);

  // Read the program counter while idle, the operand address during decode.
  assign raddr = cmd_i.decode ? fetch_opd : pc_q;

  // Memory writes come from load items and from store instructions.
  assign mem_we = cmd_i.load_wr || (cmd_i.decode && fetch_opc == OPC_STO);
  assign waddr  = cmd_i.load_wr ? in_data_i.load_address : fetch_opd;
  assign wdata  = cmd_i.load_wr ? in_data_i.load_data : acc_q;

  // Memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Next state of the architectural registers.
  always_comb begin
    pc_d   = pc_q;
    acc_d  = acc_q;
    zero_d = zero_q;
    dreg_d = dreg_q;
    ir_d   = ir_q;
    halt_d = halt_q;
    if (cmd_i.decode) begin
      ir_d = rdata_q;
      pc_d = pc_inc;
      unique case (fetch_opc)
        OPC_HLT: halt_d = 1'b1;
        OPC_SKZ: begin
          if (zero_q) begin
            pc_d = pc_inc + ADDR_W'(1);
          end
          zero_d = (acc_q == '0);
        end
        OPC_JMP: begin
          pc_d   = fetch_opd;
          zero_d = (acc_q == '0);
        end
        OPC_STO: zero_d = (acc_q == '0);
        default: ;
      endcase
    end else if (cmd_i.execute) begin
      // The operand byte is in the read register now.
      unique case (ir_opc)
        OPC_ADD: begin
          dreg_d = rdata_q;
          acc_d  = acc_q + rdata_q;
        end
        OPC_AND: acc_d = acc_q & rdata_q;
        OPC_XOR: acc_d = acc_q ^ rdata_q;
        OPC_LDA: acc_d = rdata_q;
        default: ;
      endcase
      zero_d = (acc_d == '0);
    end
  end

  // Architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      acc_q  <= '0;
      zero_q <= 1'b0;
      dreg_q <= '0;
      ir_q   <= '0;
      halt_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      acc_q  <= acc_d;
      zero_q <= zero_d;
      dreg_q <= dreg_d;
      ir_q   <= ir_d;
      halt_q <= halt_d;
    end
  end

  // Result register, loaded once the item has finished.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      out_q.pc          <= pc_q;
      out_q.acc         <= acc_q;
      out_q.zero_flag   <= zero_q;
      out_q.data_value  <= dreg_q;
      out_q.instruction <= ir_q;
      out_q.halted      <= halt_q;
    end
  end

  assign out_data_o = out_q;

  // Status for the controller.
  assign sts_o.halted        = halt_q;
  assign sts_o.needs_operand = (fetch_opc == OPC_ADD) || (fetch_opc == OPC_AND) ||
                               (fetch_opc == OPC_XOR) || (fetch_opc == OPC_LDA);

endmodule

// ----- rtl/core/acpu_ctrl.sv -----
`timescale 1ns / 1ps

module acpu_ctrl import acpu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      in_op_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  acpu_sts_t sts_i,
  output acpu_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_EXEC   = 2'd2;
  localparam logic [1:0] ST_RESP   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;
  logic       out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Sequencer: load or fetch, optional operand read, hand over result.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_op_i == ITEM_LOAD) begin
            cmd_o.load_wr = 1'b1;
            state_d       = ST_RESP;
          end else if (sts_i.halted) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = sts_i.needs_operand ? ST_EXEC : ST_RESP;
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A step transfer on a running core always goes on to decode.
  a_step_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_op_i == ITEM_STEP && !sts_i.halted) |=> state_q == ST_DECODE)
    else $error("step item did not enter decode");

  // The result register is never overwritten while a result waits.
  a_capture_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  // A new result appears only after the response state.
  a_valid_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result raised outside response state");

  // Only one datapath command is active in a cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("overlapping datapath commands");
`endif

endmodule

// ----- rtl/core/accumulator_cpu_8op.sv -----
`timescale 1ns / 1ps

// Small accumulator processor with a 32-byte unified program/data memory.
// Input channel (in_valid_i/in_ready_o/in_data_i): op = 0 writes load_data
// to memory at load_address; op = 1 executes one instruction at the program
// counter unless halted. Every input transfer produces exactly one result
// transfer on the output channel (out_valid_o/out_ready_i/out_data_o) with
// the registers. A load item or a step while halted goes straight to the
// response state; halt, skip, store and jump pass through decode; add, and,
// xor and load pass through decode and execute. The extra steps come from the
// single memory read port: one registered read for the instruction, a second
// for the operand. One item is in flight at a time: the core takes no new item
// before it has finished the last one. A new item is taken when the core is
// idle, even while the previous result still waits in the output register.
// If the receiver stalls, the next item finishes and waits in the response
// state until the output register is free.
// Reset clears the program counter, accumulator, zero and halt flags and the
// instruction and data registers; the result register and memory contents
// are undefined until written.
module accumulator_cpu_8op import acpu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  acpu_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output acpu_out_t out_data_o
);

  acpu_cmd_t cmd;
  acpu_sts_t sts;

  // Sequencer.
  acpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_op_i     (in_data_i.op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Memory, registers and result register.
  acpu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
